// ===== rtl/dudf_pkg.sv =====
package dudf_pkg;

   // Field widths
   localparam int TIME_W      = 16;
   localparam int DIST_W      = 14;
   localparam int DIFF_W      = 15;
   localparam int STATUS_W    = 2;

   // Stream and CSR port widths
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 64;
   localparam int RSP_PAD_W   = RSP_DATA_W - STATUS_W - 3 * DIST_W - DIFF_W;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 14;

   localparam int WINDOW_DEFAULT = 5;

   // distance = floor(time * 1715 / 10000) = (time * DIST_RECIP) >> RECIP_SHIFT,
   // exact for every 16-bit time (fraction steps are 1/2000, error stays below that)
   localparam int RECIP_W     = 26;
   localparam int RECIP_SHIFT = 28;
   localparam logic [RECIP_W-1:0] DIST_RECIP = 26'd46036681;

   localparam logic [DIST_W-1:0] MIN_DISTANCE_RESET = 14'd10;
   localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 14'd300;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DISTANCE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DISTANCE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_ECHO = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic dist_a_load;
      logic dist_b_load;
      logic check;
      logic sum_step;
      logic div_load;
      logic div_step;
      logic hold_load;
      logic out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic meas_ok;
      logic sum_last;
      logic div_last;
   } stat_type;

endpackage

// ===== rtl/dudf_datapath.sv =====
module dudf_datapath #(
   parameter int WINDOW = dudf_pkg::WINDOW_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [dudf_pkg::REQ_DATA_W-1:0]  req_data,
   input  logic                             csr_we,
   input  logic [dudf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dudf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  dudf_pkg::cmd_type                cmd,
   output dudf_pkg::stat_type               stat,
   output logic [dudf_pkg::RSP_DATA_W-1:0]  rsp_data
);
   import dudf_pkg::*;

   localparam int IW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW     = $clog2(WINDOW + 1);
   localparam int SW     = DIST_W + $clog2(WINDOW);
   localparam int DCW    = $clog2(SW);
   localparam int PROD_W = TIME_W + RECIP_W;

   logic [TIME_W-1:0]  time_a_ff, time_b_ff;
   logic [DIST_W-1:0]  dist_a_ff, dist_b_ff;
   logic [DIST_W-1:0]  min_ff, max_ff;
   logic [TIME_W-1:0]  mul_op;
   logic [PROD_W-1:0]  mul_prod;
   status_type         status_in, status_ff;

   logic [DIST_W-1:0]  win_a_ff [WINDOW];
   logic [DIST_W-1:0]  win_b_ff [WINDOW];
   logic [IW-1:0]      slot_ff, slot_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [IW-1:0]      idx_ff;
   logic [SW-1:0]      acc_a_ff, acc_b_ff;

   logic [SW-1:0]      dvd_a_ff, dvd_b_ff;
   logic [CW-1:0]      rem_a_ff, rem_b_ff;
   logic [CW:0]        rem_sh_a, rem_sh_b, rem_sub_a, rem_sub_b;
   logic               ge_a, ge_b;
   logic [DCW-1:0]     dcnt_ff;

   logic [DIST_W-1:0]  held_a_ff, held_b_ff, held_mean_ff;
   logic [DIFF_W-1:0]  held_diff_ff;
   logic [DIST_W:0]    pair_sum;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         time_a_ff <= req_data[TIME_W-1:0];
         time_b_ff <= req_data[2*TIME_W-1:TIME_W];
      end
   end

   // limits
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_DISTANCE_RESET;
         max_ff <= MAX_DISTANCE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_DISTANCE: min_ff <= csr_wdata;
            CSR_MAX_DISTANCE: max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared reciprocal multiplier, A then B
   assign mul_op   = cmd.dist_b_load ? time_b_ff : time_a_ff;
   assign mul_prod = PROD_W'(mul_op) * PROD_W'(DIST_RECIP);

   always_ff @(posedge clock) begin
      if (cmd.dist_a_load) dist_a_ff <= mul_prod[RECIP_SHIFT +: DIST_W];
      if (cmd.dist_b_load) dist_b_ff <= mul_prod[RECIP_SHIFT +: DIST_W];
   end

   // classification, missing echo first
   always_comb begin
      priority if (time_a_ff == '0 || time_b_ff == '0) begin
         status_in = STATUS_NO_ECHO;
      end else if (dist_a_ff < min_ff || dist_a_ff > max_ff ||
                   dist_b_ff < min_ff || dist_b_ff > max_ff) begin
         status_in = STATUS_RANGE;
      end else begin
         status_in = STATUS_OK;
      end
   end

   assign stat.meas_ok = (status_in == STATUS_OK);

   always_ff @(posedge clock) begin
      if (cmd.check) status_ff <= status_in;
   end

   // ring buffers
   assign slot_in = (slot_ff == IW'(WINDOW - 1)) ? '0 : slot_ff + IW'(1);
   assign fill_in = (fill_ff == CW'(WINDOW)) ? fill_ff : fill_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.check && stat.meas_ok) begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check && stat.meas_ok) begin
         win_a_ff[slot_ff] <= dist_a_ff;
         win_b_ff[slot_ff] <= dist_b_ff;
      end
   end

   // window sum, one entry per cycle
   always_ff @(posedge clock) begin
      if (cmd.check) begin
         idx_ff   <= '0;
         acc_a_ff <= '0;
         acc_b_ff <= '0;
      end else if (cmd.sum_step) begin
         idx_ff   <= idx_ff + IW'(1);
         acc_a_ff <= acc_a_ff + SW'(win_a_ff[idx_ff]);
         acc_b_ff <= acc_b_ff + SW'(win_b_ff[idx_ff]);
      end
   end

   assign stat.sum_last = ((CW'(idx_ff) + CW'(1)) == fill_ff);

   // restoring dividers by fill count, one quotient bit per cycle
   assign rem_sh_a  = {rem_a_ff, dvd_a_ff[SW-1]};
   assign rem_sh_b  = {rem_b_ff, dvd_b_ff[SW-1]};
   assign ge_a      = (rem_sh_a >= {1'b0, fill_ff});
   assign ge_b      = (rem_sh_b >= {1'b0, fill_ff});
   assign rem_sub_a = ge_a ? rem_sh_a - {1'b0, fill_ff} : rem_sh_a;
   assign rem_sub_b = ge_b ? rem_sh_b - {1'b0, fill_ff} : rem_sh_b;

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dvd_a_ff <= acc_a_ff;
         dvd_b_ff <= acc_b_ff;
         rem_a_ff <= '0;
         rem_b_ff <= '0;
         dcnt_ff  <= '0;
      end else if (cmd.div_step) begin
         dvd_a_ff <= {dvd_a_ff[SW-2:0], ge_a};
         dvd_b_ff <= {dvd_b_ff[SW-2:0], ge_b};
         rem_a_ff <= rem_sub_a[CW-1:0];
         rem_b_ff <= rem_sub_b[CW-1:0];
         dcnt_ff  <= dcnt_ff + DCW'(1);
      end
   end

   assign stat.div_last = (dcnt_ff == DCW'(SW - 1));

   // held results
   assign pair_sum = {1'b0, dvd_a_ff[DIST_W-1:0]} + {1'b0, dvd_b_ff[DIST_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         held_a_ff    <= '0;
         held_b_ff    <= '0;
         held_mean_ff <= '0;
         held_diff_ff <= '0;
      end else if (cmd.hold_load) begin
         held_a_ff    <= dvd_a_ff[DIST_W-1:0];
         held_b_ff    <= dvd_b_ff[DIST_W-1:0];
         held_mean_ff <= pair_sum[DIST_W:1];
         held_diff_ff <= DIFF_W'(dvd_a_ff[DIST_W-1:0]) - DIFF_W'(dvd_b_ff[DIST_W-1:0]);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, held_diff_ff, held_mean_ff,
                         held_b_ff, held_a_ff, status_ff};
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ===== rtl/dudf_ctrl.sv =====
module dudf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  dudf_pkg::stat_type stat,
   output dudf_pkg::cmd_type  cmd
);
   import dudf_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DIST_A   = 9'b000000010,
      ST_DIST_B   = 9'b000000100,
      ST_CHECK    = 9'b000001000,
      ST_SUM      = 9'b000010000,
      ST_DIV_LOAD = 9'b000100000,
      ST_DIV      = 9'b001000000,
      ST_HOLD     = 9'b010000000,
      ST_OUTPUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DIST_A;
            end
         end
         ST_DIST_A: begin
            cmd.dist_a_load = 1'b1;
            state_in        = ST_DIST_B;
         end
         ST_DIST_B: begin
            cmd.dist_b_load = 1'b1;
            state_in        = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.meas_ok ? ST_SUM : ST_OUTPUT;
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (stat.sum_last) state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            cmd.hold_load = 1'b1;
            state_in      = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/dual_ultrasonic_distance_filter.sv =====
// Dual echo distance filter. Each request carries two echo durations in
// microseconds (0 = no echo); each becomes a distance in tenths of a cm as
// floor(t * 1715 / 10000). Missing echo gives status 1, a distance outside
// [min_distance, max_distance] gives status 2; in both cases the previous
// averages are repeated and nothing is stored. A good pair goes into two
// WINDOW-deep ring buffers and the response carries the truncated averages
// over the filled entries, their truncated mean and A minus B. A rejected
// request goes from the check straight to the output register; a good one
// first walks the F filled entries (1..WINDOW) one per cycle in the summing
// counter, then runs S = 14 + clog2(WINDOW) steps of the one-bit-per-cycle
// restoring divider (17 for WINDOW = 5). The block handles one request at a
// time and takes the next one in the cycle after the response is registered,
// even while that response still waits for rsp_tready. CSR writes are taken
// at any time but belong to idle periods.
module dual_ultrasonic_distance_filter #(
   parameter int WINDOW = dudf_pkg::WINDOW_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dudf_pkg::REQ_DATA_W-1:0]  req_tdata,   // echo_time_a, echo_time_b
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dudf_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // status, average_a, average_b,
                                                         // mean_ab, difference_ab, pad
   // register writes: 0 min_distance, 1 max_distance
   input  logic                             csr_we,
   input  logic [dudf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dudf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dudf_pkg::*;

   // response field offsets
   localparam int AVG_A_LSB = STATUS_W;
   localparam int AVG_B_LSB = AVG_A_LSB + DIST_W;
   localparam int MEAN_LSB  = AVG_B_LSB + DIST_W;
   localparam int DIFF_LSB  = MEAN_LSB + DIST_W;

   cmd_type  cmd;
   stat_type stat;

   logic [STATUS_W-1:0] rsp_status;
   logic [DIST_W-1:0]   rsp_avg_a, rsp_avg_b, rsp_mean;
   logic [DIFF_W-1:0]   rsp_diff;

   dudf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dudf_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_tdata)
   );

   assign rsp_status = rsp_tdata[STATUS_W-1:0];
   assign rsp_avg_a  = rsp_tdata[AVG_A_LSB +: DIST_W];
   assign rsp_avg_b  = rsp_tdata[AVG_B_LSB +: DIST_W];
   assign rsp_mean   = rsp_tdata[MEAN_LSB +: DIST_W];
   assign rsp_diff   = rsp_tdata[DIFF_LSB +: DIFF_W];

   // one request in flight: ready drops right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // only defined status codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_NO_ECHO ||
                      rsp_status == STATUS_RANGE))
      else $error("undefined status code");

   // mean and difference always match the two averages sent with them
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_mean == DIST_W'(({1'b0, rsp_avg_a} + {1'b0, rsp_avg_b}) >> 1))
      else $error("mean does not match averages");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_diff == DIFF_W'({1'b0, rsp_avg_a} - {1'b0, rsp_avg_b}))
      else $error("difference does not match averages");

endmodule
